// ----- rtl/gpio_ed_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gpio_ed_pkg;

    localparam int PIN_COUNT = 28;
    localparam int DATA_W    = 28;
    localparam int TDATA_W   = ((DATA_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 4;
    localparam int M_TUSER_W = 1;

    typedef logic [PIN_COUNT-1:0] pins_t;

    typedef enum logic [2:0] {
        SLOT_LEVEL  = 3'd0,
        SLOT_DIR    = 3'd1,
        SLOT_SET    = 3'd2,
        SLOT_CLEAR  = 3'd3,
        SLOT_RISE   = 3'd4,
        SLOT_FALL   = 3'd5,
        SLOT_EDGE   = 3'd6,
        SLOT_ALTFN  = 3'd7
    } slot_e;

    typedef struct packed {
        logic              is_write;
        slot_e             slot;
        logic [DATA_W-1:0] wdata;
    } access_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              err;
    } result_t;

    // Map a bus word onto pins; bits above either width are dropped.
    function automatic pins_t to_pins(input logic [DATA_W-1:0] word);
        pins_t p;
        p = '0;
        for (int i = 0; i < PIN_COUNT; i++) begin
            if (i < DATA_W) begin
                p[i] = word[i];
            end
        end
        return p;
    endfunction

    function automatic logic [DATA_W-1:0] to_word(input pins_t p);
        logic [DATA_W-1:0] w;
        w = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (i < PIN_COUNT) begin
                w[i] = p[i];
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gpio_ed_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gpio_ed_in_stage (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [gpio_ed_pkg::TDATA_W-1:0]   s_tdata,
    input  wire logic [gpio_ed_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                         advance,
    output logic                              in_valid,
    output gpio_ed_pkg::access_t              access
);
    import gpio_ed_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    access_t access_reg;
    logic    s_beat;

    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_beat) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            access_reg.is_write <= s_tuser[0];
            access_reg.slot     <= slot_e'(s_tuser[3:1]);
            access_reg.wdata    <= s_tdata[DATA_W-1:0];
        end
    end

    assign in_valid = in_valid_reg;
    assign access   = access_reg;

endmodule

`default_nettype wire

// ----- rtl/gpio_ed_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gpio_ed_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 fire,
    input  wire gpio_ed_pkg::access_t access,
    output gpio_ed_pkg::result_t      result
);
    import gpio_ed_pkg::*;

    pins_t level_reg, level_next;
    pins_t dir_reg,   dir_next;
    pins_t rise_reg,  rise_next;
    pins_t fall_reg,  fall_next;
    pins_t edge_reg,  edge_next;
    pins_t altfn_reg, altfn_next;

    pins_t data;
    pins_t drive;
    pins_t rd_pins;
    logic  err;

    assign data  = to_pins(access.wdata);
    assign drive = dir_reg & data;

    always_comb begin
        level_next = level_reg;
        dir_next   = dir_reg;
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        edge_next  = edge_reg;
        altfn_next = altfn_reg;
        rd_pins    = '0;
        err        = 1'b0;
        if (!access.is_write) begin
            unique case (access.slot)
                SLOT_LEVEL: rd_pins = level_reg;
                SLOT_DIR:   rd_pins = dir_reg;
                SLOT_RISE:  rd_pins = rise_reg;
                SLOT_FALL:  rd_pins = fall_reg;
                SLOT_EDGE:  rd_pins = edge_reg;
                SLOT_ALTFN: rd_pins = altfn_reg;
                default:    err     = 1'b1;
            endcase
        end else begin
            unique case (access.slot)
                SLOT_LEVEL: err = 1'b1;
                SLOT_DIR:   dir_next = data;
                SLOT_SET: begin
                    // latch rising edges on output pins driven high
                    level_next = level_reg | drive;
                    edge_next  = edge_reg | (rise_reg & drive & ~level_reg);
                end
                SLOT_CLEAR: begin
                    level_next = level_reg & ~drive;
                    edge_next  = edge_reg | (fall_reg & drive & level_reg);
                end
                SLOT_RISE:  rise_next  = data;
                SLOT_FALL:  fall_next  = data;
                SLOT_EDGE:  edge_next  = edge_reg & ~data;
                default:    altfn_next = data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            dir_reg   <= '0;
            rise_reg  <= '0;
            fall_reg  <= '0;
            edge_reg  <= '0;
            altfn_reg <= '0;
        end else if (fire) begin
            level_reg <= level_next;
            dir_reg   <= dir_next;
            rise_reg  <= rise_next;
            fall_reg  <= fall_next;
            edge_reg  <= edge_next;
            altfn_reg <= altfn_next;
        end
    end

    assign result.rdata = to_word(rd_pins);
    assign result.err   = err;

endmodule

`default_nettype wire

// ----- rtl/gpio_ed_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gpio_ed_out_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire gpio_ed_pkg::result_t          result,
    output logic                               advance,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [gpio_ed_pkg::TDATA_W-1:0]    m_tdata,
    output logic [gpio_ed_pkg::M_TUSER_W-1:0]  m_tuser
);
    import gpio_ed_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    // move the held access forward when the result slot is free or draining
    assign advance = in_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - DATA_W){1'b0}}, result_reg.rdata};
    assign m_tuser  = result_reg.err;

endmodule

`default_nettype wire

// ----- rtl/gpio_edge_detect_registers_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// GPIO register block with set/clear outputs and edge detection. Each input
// beat is one bus access (read or write to one of eight slots: level,
// direction, set, clear, rise enable, fall enable, edge status, alternate
// function) and yields exactly one result beat carrying the read data and an
// error flag; reads of set/clear and writes of level are flagged and change
// nothing. An access passes through an input register and a result register;
// it moves on to the result register when that is free or draining, and its
// result is then presented on m_tvalid. A new access is accepted every cycle
// while the result side keeps draining, so throughput is one access per clock,
// set by the single read-modify-write of the pin state registers.
module gpio_edge_detect_registers_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // write_data[27:0], zero pad above
    input  wire logic [gpio_ed_pkg::TDATA_W-1:0]    s_tdata,
    // func[0], reg_slot[3:1]
    input  wire logic [gpio_ed_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // read_data[27:0], zero pad above
    output logic [gpio_ed_pkg::TDATA_W-1:0]         m_tdata,
    // access_error[0]
    output logic [gpio_ed_pkg::M_TUSER_W-1:0]       m_tuser
);
    import gpio_ed_pkg::*;

    logic    advance;
    logic    in_valid;
    access_t access;
    result_t result;

    gpio_ed_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .in_valid (in_valid),
        .access   (access)
    );

    gpio_ed_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .access  (access),
        .result  (result)
    );

    gpio_ed_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- rtl/gpio_ed_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gpio_ed_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [gpio_ed_pkg::TDATA_W-1:0]    m_tdata,
    input wire logic [gpio_ed_pkg::M_TUSER_W-1:0]  m_tuser
);
    import gpio_ed_pkg::*;

    // an error beat never carries register contents
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("error beat with nonzero read data");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TDATA_W-1:DATA_W] == '0))
        else $error("read data padding not zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind gpio_edge_detect_registers_top gpio_ed_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
